[hdl/assert_macros.svh]
// Assertion macros for the audio frame scanner. Every check is clocked on aclk
// and is held off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPAS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mpas assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MPAS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mpas assertion failed");

`endif

[hdl/mpas_pkg.sv]
`default_nettype none

package mpas_pkg;

    localparam int HDR_W   = 32;
    localparam int CLK_W   = 25;
    localparam int BYTES_W = 12;
    localparam int IDX_W   = 32;
    localparam int TS_W    = 63;
    localparam int FREQ_W  = 16;
    localparam int KBPS_W  = 9;
    localparam int SLOTK_W = 18;
    localparam int SAMP_W  = 11;
    localparam int NUM_W   = 26;
    localparam int MCH_W   = 26;

    localparam int ORDER_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CLK_W-1:0] CLK_RATE_RST = 25'd27000000;

    localparam logic [10:0] SYNC_WORD = 11'h7FF;
    localparam logic [1:0]  VER_RSVD  = 2'd1;
    localparam logic [1:0]  VER_1     = 2'd3;
    localparam logic [1:0]  LF_RSVD   = 2'd0;
    localparam logic [1:0]  RATE_RSVD = 2'd3;
    localparam logic [1:0]  LAYER_I   = 2'd0;
    localparam logic [1:0]  LAYER_III = 2'd2;
    localparam logic [3:0]  CODE_FREE = 4'd0;
    localparam logic [3:0]  CODE_BAD  = 4'd15;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSYNC   = 2'd1,
        ST_BADFIELD = 2'd2
    } mpas_status_t;

    // One classified header as it travels from the front to the back.
    typedef struct packed {
        mpas_status_t        status;
        logic                pad;
        logic                layer1;
        logic [KBPS_W-1:0]   kbps;
        logic [SLOTK_W-1:0]  slotk;
        logic [SAMP_W-1:0]   samples;
        logic [FREQ_W-1:0]   freq;
    } mpas_job_t;

    typedef struct packed {
        logic [IDX_W-1:0] unpadded;
        logic [IDX_W-1:0] padded;
        logic [IDX_W-1:0] order_lo;
    } mpas_cnt_t;

    localparam logic [KBPS_W-1:0] KBPS_V1 [3][16] = '{
        '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
          9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
    };

    localparam logic [KBPS_W-1:0] KBPS_V2 [3][16] = '{
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    };

    localparam logic [FREQ_W-1:0] FREQ_TAB [4][4] = '{
        '{16'd11025, 16'd12000, 16'd8000,  16'd0},
        '{16'd0,     16'd0,     16'd0,     16'd0},
        '{16'd22050, 16'd24000, 16'd16000, 16'd0},
        '{16'd44100, 16'd48000, 16'd32000, 16'd0}
    };

    // Slots per frame times 1000, and samples per frame, by layer.
    localparam logic [SLOTK_W-1:0] SLOTK_TAB [3] = '{18'd12000, 18'd144000, 18'd144000};
    localparam logic [SAMP_W-1:0]  SAMP_TAB  [3] = '{11'd384, 11'd1152, 11'd1152};
    localparam logic [SLOTK_W-1:0] SLOTK_LSF3 = 18'd72000;
    localparam logic [SAMP_W-1:0]  SAMP_LSF3  = 11'd576;

    function automatic logic [KBPS_W-1:0] kbps_lookup(input logic lsf, input logic [1:0] lay,
                                                      input logic [3:0] code);
        logic [1:0] l;
        l = (lay > LAYER_III) ? LAYER_III : lay;
        return lsf ? KBPS_V2[l][code] : KBPS_V1[l][code];
    endfunction

    function automatic logic [FREQ_W-1:0] freq_lookup(input logic [1:0] ver,
                                                      input logic [1:0] rate);
        return FREQ_TAB[ver][rate];
    endfunction

endpackage

`default_nettype wire

[hdl/mpas_front.sv]
`default_nettype none

module mpas_front #(
    parameter int ORDER_BITS = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [31:0]              s_header_word,
    input  wire logic                     q_full,
    output logic                          q_push,
    output mpas_pkg::mpas_job_t           q_job,
    output logic [ORDER_BITS-1:0]         q_order,
    output mpas_pkg::mpas_cnt_t           cnt
);
    import mpas_pkg::*;

    logic                  seen_reg;
    logic [1:0]            ver_reg;
    logic [1:0]            lay_reg;
    logic [1:0]            rate_reg;
    logic [ORDER_BITS-1:0] order_reg;
    logic [IDX_W-1:0]      unpadded_reg;
    logic [IDX_W-1:0]      padded_reg;

    logic        sync_ok;
    logic [1:0]  hv, hlf, hr, ver_c, lay_c, rate_c;
    logic [3:0]  code;
    logic        pad;
    logic        hdr_bad;
    logic        lsf;
    logic        good;
    logic [FREQ_W-1:0] freq;
    mpas_status_t      status;
    logic [ORDER_BITS+IDX_W-1:0] order_ext;

    assign sync_ok = (s_header_word[31:21] == SYNC_WORD);
    assign hv      = s_header_word[20:19];
    assign hlf     = s_header_word[18:17];
    assign code    = s_header_word[15:12];
    assign hr      = s_header_word[11:10];
    assign pad     = s_header_word[9];
    assign hdr_bad = (hv == VER_RSVD) || (hlf == LF_RSVD) || (hr == RATE_RSVD);

    // Until the first usable header, the header's own fields stand in for the latched ones.
    assign ver_c  = seen_reg ? ver_reg  : hv;
    assign lay_c  = seen_reg ? lay_reg  : 2'd3 - hlf;
    assign rate_c = seen_reg ? rate_reg : hr;
    assign freq   = freq_lookup(ver_c, rate_c);
    assign lsf    = (ver_c != VER_1);

    always_comb begin
        priority if (!sync_ok) begin
            status = ST_NOSYNC;
        end else if (!seen_reg && hdr_bad) begin
            status = ST_BADFIELD;
        end else if (code == CODE_FREE || code == CODE_BAD || freq == '0) begin
            status = ST_BADFIELD;
        end else begin
            status = ST_OK;
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign good    = q_push && (status == ST_OK);

    always_comb begin
        q_job.status  = status;
        q_job.pad     = sync_ok && pad;
        q_job.layer1  = (lay_c == LAYER_I);
        q_job.kbps    = kbps_lookup(lsf, lay_c, code);
        q_job.freq    = freq;
        if (lsf && lay_c == LAYER_III) begin
            q_job.slotk   = SLOTK_LSF3;
            q_job.samples = SAMP_LSF3;
        end else if (lay_c == LAYER_I) begin
            q_job.slotk   = SLOTK_TAB[0];
            q_job.samples = SAMP_TAB[0];
        end else if (lay_c == LAYER_III) begin
            q_job.slotk   = SLOTK_TAB[2];
            q_job.samples = SAMP_TAB[2];
        end else begin
            q_job.slotk   = SLOTK_TAB[1];
            q_job.samples = SAMP_TAB[1];
        end
    end

    assign q_order = order_reg;

    assign order_ext    = {{IDX_W{1'b0}}, order_reg};
    assign cnt.unpadded = unpadded_reg;
    assign cnt.padded   = padded_reg;
    assign cnt.order_lo = order_ext[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= 1'b0;
            ver_reg      <= '0;
            lay_reg      <= '0;
            rate_reg     <= '0;
            order_reg    <= '0;
            unpadded_reg <= '0;
            padded_reg   <= '0;
        end else begin
            if (q_push && sync_ok && !seen_reg && !hdr_bad) begin
                seen_reg <= 1'b1;
                ver_reg  <= hv;
                lay_reg  <= 2'd3 - hlf;
                rate_reg <= hr;
            end
            if (good) begin
                order_reg <= order_reg + 1'b1;
                if (pad) begin
                    padded_reg <= padded_reg + 1'b1;
                end else begin
                    unpadded_reg <= unpadded_reg + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[hdl/mpas_queue.sv]
`default_nettype none

module mpas_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] din,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      dout,
    output logic              empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/mpas_div.sv]
`default_nettype none

// Restoring divider, two quotient bits per cycle. The dividend is shifted in
// from the top, so a short dividend is left-aligned and run for fewer steps.
module mpas_div #(
    parameter int DIV_W  = 68,
    parameter int STEP_W = 6
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [DIV_W-1:0]              dividend,
    input  wire logic [mpas_pkg::FREQ_W-1:0]   divisor,
    input  wire logic [STEP_W-1:0]             steps,
    output logic                               done,
    output logic [DIV_W-1:0]                   quotient
);
    import mpas_pkg::*;

    logic [FREQ_W-1:0] rem_reg;
    logic [DIV_W-1:0]  dq_reg;
    logic [FREQ_W-1:0] dvs_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [FREQ_W:0]   r1, r2, d_ext;
    logic              ge1, ge2;
    logic [FREQ_W-1:0] r1s, r2s;
    logic [DIV_W-1:0]  dq1, dq2;

    assign d_ext = {1'b0, dvs_reg};
    assign r1    = {rem_reg, dq_reg[DIV_W-1]};
    assign ge1   = (r1 >= d_ext);
    assign r1s   = ge1 ? FREQ_W'(r1 - d_ext) : r1[FREQ_W-1:0];
    assign dq1   = {dq_reg[DIV_W-2:0], ge1};
    assign r2    = {r1s, dq1[DIV_W-1]};
    assign ge2   = (r2 >= d_ext);
    assign r2s   = ge2 ? FREQ_W'(r2 - d_ext) : r2[FREQ_W-1:0];
    assign dq2   = {dq1[DIV_W-2:0], ge2};

    assign done     = done_reg;
    assign quotient = dq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
                rem_reg  <= '0;
                dq_reg   <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= r2s;
                dq_reg  <= dq2;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[hdl/mpas_back.sv]
`default_nettype none

module mpas_back #(
    parameter int ORDER_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [mpas_pkg::CLK_W-1:0]      clk_rate,
    input  wire logic                            q_empty,
    input  wire mpas_pkg::mpas_job_t             q_job,
    input  wire logic [ORDER_BITS-1:0]           q_order,
    output logic                                 q_pop,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [1:0]                           m_status,
    output logic [mpas_pkg::BYTES_W-1:0]         m_frame_bytes,
    output logic [mpas_pkg::IDX_W-1:0]           m_frame_index,
    output logic [mpas_pkg::TS_W-1:0]            m_timestamp,
    output logic                                 m_padded
);
    import mpas_pkg::*;

    localparam int A_W    = ORDER_BITS + SAMP_W;
    localparam int P_W    = A_W + CLK_W;
    localparam int DIV_W  = P_W + (P_W % 2);
    localparam int NCH    = (A_W + MCH_W - 1) / MCH_W;
    localparam int A_PAD  = NCH * MCH_W;
    localparam int MC_W   = $clog2(NCH + 1);
    localparam int STEP_W = $clog2(DIV_W / 2 + 1);
    localparam int QX_W   = (DIV_W > TS_W + 1) ? DIV_W : TS_W + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_MUL, S_BDIV, S_TDIV, S_DONE
    } state_t;

    state_t                state_reg;
    mpas_job_t             job_reg;
    logic [ORDER_BITS-1:0] order_reg;
    logic [A_PAD-1:0]      a_sh_reg;
    logic [P_W-1:0]        acc_reg;
    logic [NUM_W-1:0]      numer_reg;
    logic [MC_W-1:0]       mcnt_reg;
    logic [BYTES_W-1:0]    bytes_reg;
    logic [TS_W-1:0]       ts_reg;
    logic                  m_valid_reg;
    logic [1:0]            m_status_reg;
    logic [BYTES_W-1:0]    m_bytes_reg;
    logic [IDX_W-1:0]      m_index_reg;
    logic [TS_W-1:0]       m_ts_reg;
    logic                  m_padded_reg;

    logic [A_W-1:0]              aprod;
    logic [KBPS_W+SLOTK_W-1:0]   nprod;
    logic [MCH_W+CLK_W-1:0]      cprod;
    logic [P_W-1:0]              acc_next;
    logic                        mul_last;
    logic                        div_start;
    logic [DIV_W-1:0]            div_dividend;
    logic [STEP_W-1:0]           div_steps;
    logic                        div_done;
    logic [DIV_W-1:0]            div_q;
    logic [QX_W-1:0]             qx;
    logic [TS_W-1:0]             ts_calc;
    logic [BYTES_W-1:0]          bq;
    logic [BYTES_W-1:0]          bytes_calc;
    logic [ORDER_BITS+IDX_W-1:0] order_ext;

    assign aprod    = A_W'(order_reg) * A_W'(job_reg.samples);
    assign nprod    = job_reg.kbps * job_reg.slotk;
    // The product is built most significant chunk first, so each cycle shifts by a fixed amount.
    assign cprod    = a_sh_reg[A_PAD-1 -: MCH_W] * clk_rate;
    assign acc_next = (acc_reg << MCH_W) + P_W'(cprod);
    assign mul_last = (mcnt_reg == MC_W'(NCH - 1));

    assign div_start    = (state_reg == S_MUL && mul_last) || (state_reg == S_BDIV && div_done);
    assign div_dividend = (state_reg == S_MUL) ? {numer_reg, {(DIV_W-NUM_W){1'b0}}}
                                               : DIV_W'(acc_reg);
    assign div_steps    = (state_reg == S_MUL) ? STEP_W'(NUM_W / 2) : STEP_W'(DIV_W / 2);

    mpas_div #(
        .DIV_W  (DIV_W),
        .STEP_W (STEP_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (job_reg.freq),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_q)
    );

    assign bq         = div_q[BYTES_W-1:0] + BYTES_W'(job_reg.pad);
    assign bytes_calc = job_reg.layer1 ? {bq[BYTES_W-3:0], 2'b00} : bq;

    assign qx      = QX_W'(div_q);
    assign ts_calc = (|qx[QX_W-1:TS_W]) ? '1 : qx[TS_W-1:0];

    assign order_ext = {{IDX_W{1'b0}}, order_reg};
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_frame_bytes = m_bytes_reg;
    assign m_frame_index = m_index_reg;
    assign m_timestamp   = m_ts_reg;
    assign m_padded      = m_padded_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            mcnt_reg    <= '0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        job_reg   <= q_job;
                        order_reg <= q_order;
                        bytes_reg <= '0;
                        ts_reg    <= '0;
                        state_reg <= (q_job.status == ST_OK) ? S_PREP : S_DONE;
                    end
                end
                S_PREP: begin
                    a_sh_reg  <= A_PAD'(aprod);
                    numer_reg <= nprod[NUM_W-1:0];
                    acc_reg   <= '0;
                    mcnt_reg  <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    acc_reg  <= acc_next;
                    a_sh_reg <= a_sh_reg << MCH_W;
                    mcnt_reg <= mcnt_reg + 1'b1;
                    if (mul_last) begin
                        state_reg <= S_BDIV;
                    end
                end
                S_BDIV: begin
                    if (div_done) begin
                        bytes_reg <= bytes_calc;
                        state_reg <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (div_done) begin
                        ts_reg    <= ts_calc;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= job_reg.status;
                        m_bytes_reg  <= bytes_reg;
                        m_index_reg  <= order_ext[IDX_W-1:0];
                        m_ts_reg     <= ts_reg;
                        m_padded_reg <= job_reg.pad;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/mpeg_audio_frame_scanner.sv]
// Channel   Valid / ready          Payload
// s_        s_valid / s_ready      s_header_word
// m_        m_valid / m_ready      m_status, m_frame_bytes, m_frame_index,
//                                  m_timestamp, m_padded
// cfg_      cfg_valid / cfg_ready  cfg_wdata (timestamp clock rate)
//
// In the back end a good header passes S_PREP, S_MUL, S_BDIV and S_TDIV; the
// two-bit-per-cycle divider runs once for the frame length and once for the timestamp.
// A header that fails goes from S_IDLE straight to S_DONE.
// Reset is synchronous and active low; no clearing pass is needed after it.
// A two-beat queue parts the header classifier from the arithmetic, so input beats are
// taken while a result waits on m_ready, until the queue is full.
`default_nettype none

`include "assert_macros.svh"

module mpeg_audio_frame_scanner #(
    parameter int ORDER_BITS = mpas_pkg::ORDER_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mpas_pkg::CLK_W-1:0]    cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [mpas_pkg::HDR_W-1:0]    s_header_word,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_status,
    output logic [mpas_pkg::BYTES_W-1:0]       m_frame_bytes,
    output logic [mpas_pkg::IDX_W-1:0]         m_frame_index,
    output logic [mpas_pkg::TS_W-1:0]          m_timestamp,
    output logic                               m_padded
);
    import mpas_pkg::*;

    localparam int Q_W = $bits(mpas_job_t) + ORDER_BITS;
    localparam logic [IDX_W-1:0] ORDER_MASK =
        (ORDER_BITS >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((64'd1 << ORDER_BITS) - 64'd1);

    logic [CLK_W-1:0]      clk_rate_reg;
    logic                  q_push, q_pop, q_full, q_empty;
    mpas_job_t             f_job, b_job;
    logic [ORDER_BITS-1:0] f_order, b_order;
    logic [Q_W-1:0]        q_dout;
    mpas_cnt_t             cnt;
    logic [IDX_W-1:0]      cnt_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_rate_reg <= CLK_RATE_RST;
        end else if (cfg_valid) begin
            clk_rate_reg <= cfg_wdata;
        end
    end

    mpas_front #(
        .ORDER_BITS (ORDER_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_header_word (s_header_word),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (f_job),
        .q_order       (f_order),
        .cnt           (cnt)
    );

    mpas_queue #(
        .W     (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     ({f_job, f_order}),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    assign b_job   = q_dout[Q_W-1:ORDER_BITS];
    assign b_order = q_dout[ORDER_BITS-1:0];

    mpas_back #(
        .ORDER_BITS (ORDER_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clk_rate      (clk_rate_reg),
        .q_empty       (q_empty),
        .q_job         (b_job),
        .q_order       (b_order),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_frame_bytes (m_frame_bytes),
        .m_frame_index (m_frame_index),
        .m_timestamp   (m_timestamp),
        .m_padded      (m_padded)
    );

    assign cnt_sum = cnt.unpadded + cnt.padded;

    // Every good frame bumps exactly one padding count and the order count.
    `MPAS_ASSERT_IMP(a_count_sum, 1'b1, (cnt_sum & ORDER_MASK) == (cnt.order_lo & ORDER_MASK))
    `MPAS_ASSERT_IMP(a_err_zero, m_valid && m_status != ST_OK,
        m_frame_bytes == '0 && m_timestamp == '0)
    `MPAS_ASSERT_IMP(a_nosync_pad, m_valid && m_status == ST_NOSYNC, !m_padded)
    `MPAS_ASSERT_NXT(a_pop_order, q_pop && q_empty, 1'b0)

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import mpas_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          PHASE_ITEMS   = 240;
    localparam int          SETTLE_CYCLES = 80;
    localparam logic [1:0]  VER_2_5       = 2'd0;
    localparam logic [1:0]  VER_2         = 2'd2;

    // Bitrates in kbit/s by layer (I, II, III) and bitrate code.
    localparam int unsigned KBPS_MPEG1 [3][16] = '{
        '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
        '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}
    };
    localparam int unsigned KBPS_LSF [3][16] = '{
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
        '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
        '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
    };
    localparam int unsigned FREQ_HZ [4][4] = '{
        '{11025, 12000, 8000, 0},
        '{0, 0, 0, 0},
        '{22050, 24000, 16000, 0},
        '{44100, 48000, 32000, 0}
    };
    localparam int unsigned SLOTS   [3] = '{12, 144, 144};
    localparam int unsigned SAMPLES [3] = '{384, 1152, 1152};

    typedef struct {
        mpas_status_t status;
        logic [11:0]  bytes;
        logic [31:0]  index;
        logic [62:0]  pts;
        logic         padded;
    } frame_result_t;

    typedef struct {
        logic [31:0]  word;
        bit           typed;
        mpas_status_t status;
        logic         padded;
        logic [31:0]  index;
    } header_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [24:0] cfg_wdata     = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [31:0] s_header_word = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [11:0] m_frame_bytes;
    logic [31:0] m_frame_index;
    logic [62:0] m_timestamp;
    logic        m_padded;

    // Predictor state.
    logic [24:0] tick_rate   = 25'd27000000;
    logic [31:0] next_index  = '0;
    bit          latched     = 1'b0;
    logic [1:0]  lat_version = '0;
    logic [1:0]  lat_layer   = '0;
    logic [1:0]  lat_rate    = '0;
    logic [31:0] pad_tally [2] = '{32'd0, 32'd0};

    frame_result_t pending_frames [$];
    header_row_t   directed_rows [$];
    bit            row_typed  = 1'b0;
    frame_result_t row_expect;
    int            results_seen   = 0;
    int            mismatch_count = 0;
    int            cycle_count    = 0;

    always #6 aclk = ~aclk;

    mpeg_audio_frame_scanner i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_header_word (s_header_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_frame_bytes (m_frame_bytes),
        .m_frame_index (m_frame_index),
        .m_timestamp   (m_timestamp),
        .m_padded      (m_padded)
    );

    function automatic frame_result_t scan_header(input logic [31:0] w);
        frame_result_t res;
        logic [1:0]    v, lf, r;
        logic [3:0]    code;
        logic          pad;
        bit            lsf;
        int unsigned   freq, kbps, slots, samples, nbytes;
        logic [127:0]  prod, quo;
        res.status = ST_OK;
        res.bytes  = '0;
        res.index  = next_index;
        res.pts    = '0;
        res.padded = 1'b0;
        if (w[31:21] != SYNC_WORD) begin
            res.status = ST_NOSYNC;
            return res;
        end
        pad        = w[9];
        code       = w[15:12];
        res.padded = pad;
        if (!latched) begin
            v  = w[20:19];
            lf = w[18:17];
            r  = w[11:10];
            if (v == VER_RSVD || lf == LF_RSVD || r == RATE_RSVD) begin
                res.status = ST_BADFIELD;
                return res;
            end
            lat_version = v;
            lat_layer   = 2'd3 - lf;
            lat_rate    = r;
            latched     = 1'b1;
        end
        freq = FREQ_HZ[lat_version][lat_rate];
        if (code == CODE_FREE || code == CODE_BAD || freq == 0) begin
            res.status = ST_BADFIELD;
            return res;
        end
        lsf     = (lat_version != VER_1);
        kbps    = lsf ? KBPS_LSF[lat_layer][code] : KBPS_MPEG1[lat_layer][code];
        slots   = SLOTS[lat_layer];
        samples = SAMPLES[lat_layer];
        // Layer III at the lower sampling rates carries half the samples per frame.
        if (lsf && lat_layer == LAYER_III) begin
            slots   = 72;
            samples = 576;
        end
        nbytes = kbps * slots * 1000 / freq + pad;
        if (lat_layer == LAYER_I)
            nbytes = nbytes * 4;
        res.bytes = nbytes[11:0];
        prod = 128'(next_index);
        prod = prod * samples;
        prod = prod * tick_rate;
        quo  = prod / freq;
        res.pts = (quo > 128'h7FFF_FFFF_FFFF_FFFF) ? '1 : quo[62:0];
        next_index     = next_index + 1;
        pad_tally[pad] = pad_tally[pad] + 1;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("MISMATCH %s: got %0d, expected %0d at %0t ns", what, got, want, $time);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Both handshakes are sampled here, inputs first, so the store of expected frames
    // always runs in acceptance order.
    always @(posedge aclk) begin
        frame_result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                tick_rate = cfg_wdata;
            if (s_valid && s_ready) begin
                want = scan_header(s_header_word);
                if (row_typed)
                    want = row_expect;
                pending_frames.push_back(want);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_frames.size() == 0) begin
                    report_mismatch("frame with none pending, index", m_frame_index, 0);
                end else begin
                    want = pending_frames.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_frame_bytes !== want.bytes)
                        report_mismatch("frame_bytes", m_frame_bytes, want.bytes);
                    if (m_frame_index !== want.index)
                        report_mismatch("frame_index", m_frame_index, want.index);
                    if (m_timestamp !== want.pts)
                        report_mismatch("timestamp", m_timestamp, want.pts);
                    if (m_padded !== want.padded)
                        report_mismatch("padded", m_padded, want.padded);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("mpeg_audio_frame_scanner test failed");
            $finish;
        end
    end

    // Result side: random stalls, a few long ready stretches, and one long hold-off
    // that fills the block and pushes back on the header channel.
    initial begin
        int  stretch, stall;
        bit  held;
        held = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (!held && results_seen >= 100) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (600) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400)
                                                     : $urandom_range(1, 30);
                repeat (stretch) @(negedge aclk);
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
        end
    end

    function automatic logic [31:0] build_header(input logic [3:0] code, input logic pad,
                                                 input logic [1:0] v, input logic [1:0] lf,
                                                 input logic [1:0] r);
        return {SYNC_WORD, v, lf, 1'($urandom_range(0, 1)), code, r, pad,
                9'($urandom_range(0, 511))};
    endfunction

    task automatic add_row(input logic [31:0] w, input bit typed, input mpas_status_t st,
                           input logic pad, input logic [31:0] idx);
        header_row_t row;
        row.word   = w;
        row.typed  = typed;
        row.status = st;
        row.padded = pad;
        row.index  = idx;
        directed_rows.push_back(row);
    endtask

    // Offers one header beat after the given gap and returns at the falling edge
    // that follows its acceptance.
    task automatic send_header(input header_row_t row, input int gap);
        frame_result_t typed_result;
        typed_result.status = row.status;
        typed_result.bytes  = '0;
        typed_result.index  = row.index;
        typed_result.pts    = '0;
        typed_result.padded = row.padded;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_header_word <= row.word;
        row_typed     <= row.typed;
        row_expect    <= typed_result;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_clock_rate(input logic [24:0] rate);
        s_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= rate;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [1:0]  ver_pick, lf_pick, rate_pick;
        logic [24:0] rate_plan [6];
        header_row_t row;
        int          gap, burst_left, r;
        logic [31:0] word;

        // The stream format is fixed by the first usable header, so each run picks one.
        r = $urandom_range(0, 2);
        ver_pick  = (r == 0) ? VER_2_5 : (r == 1) ? VER_2 : VER_1;
        lf_pick   = 2'($urandom_range(1, 3));
        rate_pick = 2'($urandom_range(0, 2));

        add_row(32'h0000_0000, 1'b1, ST_NOSYNC, 1'b0, 32'd0);
        add_row(32'hFFFF_FFFF, 1'b1, ST_BADFIELD, 1'b1, 32'd0);
        add_row(build_header(4'd5, 1'b0, VER_RSVD, lf_pick, rate_pick), 1'b1, ST_BADFIELD,
                1'b0, 32'd0);
        add_row(build_header(4'd5, 1'b1, ver_pick, LF_RSVD, rate_pick), 1'b1, ST_BADFIELD,
                1'b1, 32'd0);
        add_row(build_header(4'd5, 1'b0, ver_pick, lf_pick, RATE_RSVD), 1'b1, ST_BADFIELD,
                1'b0, 32'd0);
        // A free-format header still latches the stream format.
        add_row(build_header(CODE_FREE, 1'b1, ver_pick, lf_pick, rate_pick),
                1'b1, ST_BADFIELD, 1'b1, 32'd0);
        add_row(build_header(4'd1, 1'b0, ver_pick, lf_pick, rate_pick), 1'b0, ST_OK,
                1'b0, 32'd0);
        add_row(build_header(4'd14, 1'b1, ver_pick, lf_pick, rate_pick), 1'b0, ST_OK,
                1'b0, 32'd0);
        add_row(build_header(CODE_BAD, 1'b0, ver_pick, lf_pick, rate_pick),
                1'b1, ST_BADFIELD, 1'b0, 32'd2);
        add_row(32'hFFDF_FFFF, 1'b1, ST_NOSYNC, 1'b0, 32'd2);
        // Reserved format fields are ignored once the format is latched.
        add_row(build_header(4'd7, 1'b1, VER_RSVD, LF_RSVD, RATE_RSVD), 1'b0, ST_OK,
                1'b0, 32'd0);
        for (int c = 1; c <= 14; c++)
            add_row(build_header(4'(c), c[0], ver_pick, lf_pick, rate_pick), 1'b0, ST_OK,
                    1'b0, 32'd0);

        rate_plan[0] = 25'd1;
        rate_plan[1] = 25'h1FF_FFFF;
        rate_plan[2] = 25'd0;
        rate_plan[3] = 25'd90000;
        rate_plan[4] = 25'($urandom_range(1, 27000000));
        rate_plan[5] = 25'd27000000;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_header(directed_rows[i], pick_gap());

        burst_left = 0;
        for (int p = 0; p < 6; p++) begin
            // Each setting change waits for the block to drain first.
            write_clock_rate(rate_plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                word = {SYNC_WORD, 21'($urandom())};
                if (r >= 80 && r < 90)
                    word[$urandom_range(21, 31)] = ~word[$urandom_range(21, 31)];
                else if (r >= 90)
                    word = $urandom();
                row.word   = word;
                row.typed  = 1'b0;
                row.status = ST_OK;
                row.padded = 1'b0;
                row.index  = '0;
                if (burst_left > 0) begin
                    burst_left--;
                    gap = 0;
                end else begin
                    if ($urandom_range(0, 19) == 0)
                        burst_left = $urandom_range(10, 30);
                    gap = pick_gap();
                end
                send_header(row, gap);
            end
        end

        s_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("mpeg_audio_frame_scanner test passed");
        else
            $display("mpeg_audio_frame_scanner test failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/mpas_pkg.sv
hdl/mpas_front.sv
hdl/mpas_queue.sv
hdl/mpas_div.sv
hdl/mpas_back.sv
hdl/mpeg_audio_frame_scanner.sv
tb/sv/testbench.sv
